>>> hw/rtl/ffxp_pkg.sv
package ffxp_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned DUTY_W      = 2 * BYTE_W;
   localparam int unsigned PAYLOAD_LEN = 5;
   localparam int unsigned POS_W       = 3;
   localparam int unsigned IDX_W       = $clog2(PAYLOAD_LEN);

   localparam logic [BYTE_W-1:0] SYNC_BYTE_RESET = 8'hAA;

   // frame position codes: hunting, first payload word, checksum word
   localparam logic [POS_W-1:0] POS_HUNT     = 3'd0;
   localparam logic [POS_W-1:0] POS_FIRST    = 3'd1;
   localparam logic [POS_W-1:0] POS_CHECKSUM = 3'd6;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] instruction_type;
      logic [DUTY_W-1:0] left_duty;
      logic [DUTY_W-1:0] right_duty;
   } result_type;

   typedef struct packed {
      logic       at_checksum;
      result_type result;
   } frame_status_type;

endpackage

>>> hw/rtl/ffxp_frame.sv
module ffxp_frame
   import ffxp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [BYTE_W-1:0]     rx_byte,
   input  logic [BYTE_W-1:0]     sync_byte,
   output frame_status_type      status
);

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] xor_ff, xor_in;
   logic [BYTE_W-1:0] payload_ff [PAYLOAD_LEN];
   logic              hunting;
   logic              store_word;
   logic [IDX_W-1:0]  store_idx;
   result_type        result;

   // position seven is never reached, treat it as hunting anyway
   assign hunting    = (pos_ff == POS_HUNT) || (pos_ff > POS_CHECKSUM);
   assign store_word = accept && !hunting && (pos_ff < POS_CHECKSUM);
   assign store_idx  = IDX_W'(pos_ff - POS_FIRST);

   always_comb begin
      pos_in = pos_ff;
      xor_in = xor_ff;
      result = '0;
      result.instruction_type = payload_ff[0];
      result.left_duty        = {payload_ff[1], payload_ff[2]};
      result.right_duty       = {payload_ff[3], payload_ff[4]};
      if (accept) begin
         if (hunting) begin
            pos_in = (rx_byte == sync_byte) ? POS_FIRST : POS_HUNT;
            xor_in = '0;
         end else if (pos_ff < POS_CHECKSUM) begin
            pos_in = pos_ff + POS_FIRST;
            xor_in = xor_ff ^ rx_byte;
         end else begin
            // checksum word: a mismatch drops the frame
            pos_in       = POS_HUNT;
            result.valid = (xor_ff == rx_byte);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      xor_ff <= xor_in;
      if (store_word) begin
         payload_ff[store_idx] <= rx_byte;
      end
   end

   assign status.at_checksum = (pos_ff == POS_CHECKSUM);
   assign status.result      = result;

endmodule

>>> hw/rtl/ffxp_out.sv
module ffxp_out
   import ffxp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  result_type        result,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [BYTE_W-1:0] rsp_instruction_type,
   output logic [DUTY_W-1:0] rsp_left_duty,
   output logic [DUTY_W-1:0] rsp_right_duty
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] instr_ff;
   logic [DUTY_W-1:0] left_ff;
   logic [DUTY_W-1:0] right_ff;

   // a new result only arrives when the register is free or being drained
   assign valid_in = result.valid || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         instr_ff <= result.instruction_type;
         left_ff  <= result.left_duty;
         right_ff <= result.right_duty;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_instruction_type = instr_ff;
   assign rsp_left_duty        = left_ff;
   assign rsp_right_duty       = right_ff;

endmodule

>>> hw/rtl/fixed_frame_xor_checked_parser_top.sv
// fixed-length frame parser with xor check
// input channel (req_): one received byte per word, valid/ready handshake
// result channel (rsp_): instruction byte and two big-endian 16-bit duty values
// csr_: write enable and data for the start byte, reset value 0xAA
// a frame is the start byte, five payload words and a checksum word; the
// checksum must equal the xor of the five payload words or the frame is dropped
// start bytes inside a frame are plain data, there is no resync or timeout
// throughput: one input word per cycle unless a checksum word waits, set by the single frame-tracking stage
// the result is registered and shows on rsp_ in the cycle after the checksum word is taken
// when the receiver stalls the result waits in the output register; bytes
// other than a checksum are still taken, a checksum word waits until the
// output register is free or drained in that same cycle
// reset: hunting for the start byte, no result pending, start byte 0xAA
module fixed_frame_xor_checked_parser_top
   import ffxp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [BYTE_W-1:0] req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_instruction_type,
   output logic [DUTY_W-1:0] rsp_left_duty,
   output logic [DUTY_W-1:0] rsp_right_duty,
   input  logic              csr_write_en,
   input  logic [BYTE_W-1:0] csr_write_data
);

   logic [BYTE_W-1:0] sync_byte_ff;
   logic              accept;
   frame_status_type  status;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_byte_ff <= SYNC_BYTE_RESET;
      end else if (csr_write_en) begin
         sync_byte_ff <= csr_write_data;
      end
   end

   assign req_ready = !status.at_checksum || !rsp_valid || rsp_ready;
   assign accept    = req_valid && req_ready;

   ffxp_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .rx_byte    (req_rx_byte),
      .sync_byte  (sync_byte_ff),
      .status     (status)
   );

   ffxp_out u_out (
      .clock                (clock),
      .reset                (reset),
      .result               (status.result),
      .rsp_ready            (rsp_ready),
      .rsp_valid            (rsp_valid),
      .rsp_instruction_type (rsp_instruction_type),
      .rsp_left_duty        (rsp_left_duty),
      .rsp_right_duty       (rsp_right_duty)
   );

endmodule

>>> hw/rtl/ffxp_checker.sv
module ffxp_checker
   import ffxp_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic [BYTE_W-1:0] rsp_instruction_type,
   input  logic [DUTY_W-1:0] rsp_left_duty,
   input  logic [DUTY_W-1:0] rsp_right_duty
);

   // reset leaves no result pending
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // a new result only follows an accepted word
   a_rise_from_word: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result appeared without an input word");

   // with nothing pending the input side never stalls
   a_ready_when_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty output");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_instruction_type)
         && $stable(rsp_left_duty) && $stable(rsp_right_duty))
      else $error("stalled result changed");

endmodule

bind fixed_frame_xor_checked_parser_top ffxp_checker u_ffxp_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_valid),
   .req_ready            (req_ready),
   .rsp_valid            (rsp_valid),
   .rsp_ready            (rsp_ready),
   .rsp_instruction_type (rsp_instruction_type),
   .rsp_left_duty        (rsp_left_duty),
   .rsp_right_duty       (rsp_right_duty)
);
